FILE: hdl/sidc_pkg.sv
// Types, constants and the control-store table for the signed integer to
// decimal text converter. No dependencies.
package sidc_pkg;

   localparam int MAG_WIDTH  = 32;
   localparam int NUM_DIGITS = 10;
   localparam int BCD_WIDTH  = 4 * NUM_DIGITS;
   localparam int CNT_WIDTH  = $clog2(MAG_WIDTH);
   localparam int NDIG_WIDTH = $clog2(NUM_DIGITS + 1);
   localparam int CODE_WIDTH = 6;

   localparam logic [CODE_WIDTH-1:0] CHAR_MINUS = 6'd45;
   localparam logic [CODE_WIDTH-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CODE_WIDTH-1:0] CHAR_NINE  = 6'd57;

   typedef enum logic [2:0] {
      STEP_IDLE,
      STEP_CONV,
      STEP_SKIP,
      STEP_SIGN,
      STEP_DIGIT
   } step_type;

   typedef enum logic [2:0] {
      OP_WAIT,
      OP_DABBLE,
      OP_SKIP,
      OP_SIGN,
      OP_DIGIT
   } op_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_GO,
      COND_CNT_NZ,
      COND_LEAD_ZERO,
      COND_MORE_DIGITS
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type on_true;
      step_type on_false;
   } ucode_word_type;

   typedef struct packed {
      op_type op;
      logic   busy;
   } ctrl_type;

   typedef struct packed {
      logic go;
      logic cnt_nz;
      logic lead_zero;
      logic more_digits;
   } status_type;

   // Control store: one word per step.
   function automatic ucode_word_type ucode_rom(input step_type step);
      ucode_word_type word;
      case (step)
         STEP_IDLE:  word = '{OP_WAIT,   COND_GO,          STEP_CONV,  STEP_IDLE};
         STEP_CONV:  word = '{OP_DABBLE, COND_CNT_NZ,      STEP_CONV,  STEP_SKIP};
         STEP_SKIP:  word = '{OP_SKIP,   COND_LEAD_ZERO,   STEP_SKIP,  STEP_SIGN};
         STEP_SIGN:  word = '{OP_SIGN,   COND_ALWAYS,      STEP_DIGIT, STEP_DIGIT};
         STEP_DIGIT: word = '{OP_DIGIT,  COND_MORE_DIGITS, STEP_DIGIT, STEP_IDLE};
         default:    word = '{OP_WAIT,   COND_ALWAYS,      STEP_IDLE,  STEP_IDLE};
      endcase
      return word;
   endfunction

endpackage

FILE: hdl/sidc_ucode.sv
// Microcode sequencer: step counter, control-store lookup, conditional jumps.
// Depends on sidc_pkg.
module sidc_ucode (
   input  logic                  clock,
   input  logic                  reset,
   input  sidc_pkg::status_type  status,
   output sidc_pkg::ctrl_type    ctrl
);
   import sidc_pkg::*;

   step_type       step_ff;
   step_type       step_in;
   ucode_word_type word;
   logic           cond_true;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      word = ucode_rom(step_ff);
      case (word.cond)
         COND_ALWAYS:      cond_true = 1'b1;
         COND_GO:          cond_true = status.go;
         COND_CNT_NZ:      cond_true = status.cnt_nz;
         COND_LEAD_ZERO:   cond_true = status.lead_zero;
         COND_MORE_DIGITS: cond_true = status.more_digits;
         default:          cond_true = 1'b0;
      endcase
      step_in   = cond_true ? word.on_true : word.on_false;
      ctrl.op   = word.op;
      ctrl.busy = (step_ff != STEP_IDLE);
   end

endmodule

FILE: hdl/signed_int_to_decimal_chars.sv
// Top level of the signed 32-bit integer to decimal ASCII converter: datapath,
// result register and control register. Depends on sidc_pkg and sidc_ucode.
//
// Usage:
//   Request: drive req_value and pulse start while busy is low; the request
//   is taken at that edge. busy stays high while the number is converted and
//   its characters are formed, then drops so the next request can be taken.
//   Results: rsp_valid marks one character for exactly one cycle, with
//   rsp_char_code ('-' or '0'..'9') and rsp_last_char on the final one.
//   The receiver cannot stall; characters stream one per cycle.
//   Steps: the idle step, shift-and-add-3 binary to BCD over all 32
//   magnitude bits, a skip step that drops leading zeros (up to 9) and then
//   finds the leading digit, the sign step, then one digit step per digit.
//   Dropped zeros and emitted digits always add up to 10. busy is high
//   from the accepting edge until the last digit step, and the next request
//   can be taken in the cycle busy drops. Results appear in the cycle after
//   their step, through the output register.
//   Config: csr_output_enable is written when csr_valid and csr_ready are
//   both high; csr_ready is high while the block is idle. With output
//   disabled a request is taken and produces no characters.
//   Reset: synchronous, active high; returns to idle with output enabled.
module signed_int_to_decimal_chars (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [sidc_pkg::MAG_WIDTH-1:0] req_value,
   output logic                                rsp_valid,
   output logic [sidc_pkg::CODE_WIDTH-1:0]     rsp_char_code,
   output logic                                rsp_last_char,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_output_enable
);
   import sidc_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   // control register
   logic enable_ff;

   // datapath registers
   logic [MAG_WIDTH-1:0]  mag_ff,  mag_in;
   logic [BCD_WIDTH-1:0]  bcd_ff,  bcd_in;
   logic [CNT_WIDTH-1:0]  cnt_ff,  cnt_in;
   logic [NDIG_WIDTH-1:0] ndig_ff, ndig_in;
   logic                  neg_ff,  neg_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CODE_WIDTH-1:0] rsp_code_ff,  rsp_code_in;
   logic                  rsp_last_ff,  rsp_last_in;

   logic                  accept;
   logic [BCD_WIDTH-1:0]  bcd_adj;
   logic [3:0]            top_digit;

   sidc_ucode u_ucode (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   assign busy          = ctrl.busy;
   assign csr_ready     = !ctrl.busy;
   assign accept        = start && !ctrl.busy;
   assign top_digit     = bcd_ff[BCD_WIDTH-1 -: 4];
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_code_ff;
   assign rsp_last_char = rsp_last_ff;

   // condition flags for the sequencer
   assign status.go          = accept && enable_ff;
   assign status.cnt_nz      = (cnt_ff != '0);
   assign status.more_digits = (ndig_ff != NDIG_WIDTH'(1));
   assign status.lead_zero   = (top_digit == 4'd0) && status.more_digits;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         enable_ff <= csr_output_enable;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      cnt_ff      <= cnt_in;
      ndig_ff     <= ndig_in;
      neg_ff      <= neg_in;
      rsp_code_ff <= rsp_code_in;
      rsp_last_ff <= rsp_last_in;
   end

   // add-3 correction on every BCD digit that is 5 or more
   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   always_comb begin
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      ndig_in      = ndig_ff;
      neg_in       = neg_ff;
      rsp_valid_in = 1'b0;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = 1'b0;
      case (ctrl.op)
         OP_WAIT: begin
            if (accept) begin
               neg_in  = req_value[MAG_WIDTH-1];
               // two's complement magnitude; the most negative value maps to 2^31
               mag_in  = req_value[MAG_WIDTH-1] ? (~req_value + 1'b1) : req_value;
               bcd_in  = '0;
               cnt_in  = CNT_WIDTH'(MAG_WIDTH - 1);
               ndig_in = NDIG_WIDTH'(NUM_DIGITS);
            end
         end
         OP_DABBLE: begin
            bcd_in = {bcd_adj[BCD_WIDTH-2:0], mag_ff[MAG_WIDTH-1]};
            mag_in = {mag_ff[MAG_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
         end
         OP_SKIP: begin
            if (status.lead_zero) begin
               bcd_in  = {bcd_ff[BCD_WIDTH-5:0], 4'd0};
               ndig_in = ndig_ff - 1'b1;
            end
         end
         OP_SIGN: begin
            rsp_valid_in = neg_ff;
            rsp_code_in  = CHAR_MINUS;
         end
         OP_DIGIT: begin
            rsp_valid_in = 1'b1;
            rsp_code_in  = CHAR_ZERO + {2'b00, top_digit};
            rsp_last_in  = !status.more_digits;
            bcd_in       = {bcd_ff[BCD_WIDTH-5:0], 4'd0};
            ndig_in      = ndig_ff - 1'b1;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // an enabled request always starts a conversion
   a_go_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && enable_ff) |=> busy)
      else $error("enabled request did not start conversion");

   // a disabled request produces nothing and leaves the block idle
   a_off_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !enable_ff) |=> (!busy && !rsp_valid))
      else $error("disabled request was not dropped");

   // the last character is shown as the sequencer returns to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_char) |-> !busy)
      else $error("last character without end of request");

   // a character that is not the last one is always followed by more work
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_char) |-> busy)
      else $error("request ended before its last character");

   // only a minus sign or a decimal digit ever leaves the block
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char_code == CHAR_MINUS ||
                     (rsp_char_code >= CHAR_ZERO && rsp_char_code <= CHAR_NINE)))
      else $error("character code out of range");

endmodule
